>>> src/soc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soc_pkg: shared types and constants
// Codes, field widths and the word formats passed between the root cells,
// the divider and the top level of the segment collision check.
// ----------------------------------------------------------------------------
package soc_pkg;

  // Coordinate and register widths
  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int FRAC_W  = 16;
  localparam int CFG_IDX_W = 3;

  // Square root: 2*SQ_W bit radicand, one result bit per cell
  localparam int SQ_W = 25;
  localparam int SQ_REM_W = SQ_W + 2;

  // Shared divider width
  localparam int DIV_W = 26;

  // Defaults for top-level parameters
  localparam int OBSTACLE_DEPTH_DEF = 1024;
  localparam int MAX_STEPS_DEF = 1024;

  // Input modes
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_CHECK = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // Result status
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_LONG = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING = 3'd5;

  // Register reset values
  localparam logic signed [COORD_W-1:0] RST_MIN = 24'sh800000;
  localparam logic signed [COORD_W-1:0] RST_MAX = 24'sh7FFFFF;
  localparam logic [FRAC_W-1:0] RST_RADIUS  = 16'd256;
  localparam logic [FRAC_W-1:0] RST_SPACING = 16'd128;

  // Word moved from one root cell to the next
  typedef struct packed {
    logic                  valid;
    logic [SQ_REM_W-1:0]   rem;
    logic [SQ_W-1:0]       root;
    logic [2*SQ_W-1:0]     n;
  } sq_cell_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage

>>> src/segment_obstacle_collision_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_obstacle_collision_check: obstacle table and segment check
// Holds obstacle points and tells whether a sampled segment stays clear of
// every obstacle and inside the configured bounds.
// ----------------------------------------------------------------------------
//
//  channel  | side   | handshake             | payload
//  ---------+--------+-----------------------+-----------------------------
//  input    | sink   | in_valid / in_stall   | mode, x_a, y_a, x_b, y_b
//  result   | source | out_valid / out_stall | path_free, status,
//           |        |                       | obstacle_count
//  config   | sink   | cfg_write             | cfg_index, cfg_data
//
//  Clear, add and unused modes go straight to the result. A check squares and
//  sums the differences, takes the root in the square root cell row and uses
//  the shared divider for the step count and for each axis. It then scans
//  through the single read port of the obstacle memory: one obstacle a cycle
//  per sample point. The scan ends at the first blocked point or at the first
//  point outside the bounds. One word is in work at a time.
//  rst is synchronous; it clears the count and restores register defaults.
//  The obstacle memory has no clearing pass; entries at or above the count
//  are never read. out_stall holds the result register; a new word is taken
//  while an old result still waits.
//
module segment_obstacle_collision_check #(
  parameter int OBSTACLE_DEPTH = soc_pkg::OBSTACLE_DEPTH_DEF,
  parameter int MAX_STEPS      = soc_pkg::MAX_STEPS_DEF,
  localparam int CW = $clog2(OBSTACLE_DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        mode,
  input  logic signed [soc_pkg::COORD_W-1:0] x_a,
  input  logic signed [soc_pkg::COORD_W-1:0] y_a,
  input  logic signed [soc_pkg::COORD_W-1:0] x_b,
  input  logic signed [soc_pkg::COORD_W-1:0] y_b,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              path_free,
  output logic [1:0]                        status,
  output logic [CW-1:0]                     obstacle_count,
  // configuration
  input  logic                              cfg_write,
  input  logic [soc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [soc_pkg::COORD_W-1:0]       cfg_data
);

  localparam int AW = (OBSTACLE_DEPTH > 1) ? $clog2(OBSTACLE_DEPTH) : 1;
  localparam int SW = $clog2(MAX_STEPS + 1);
  localparam int CO = soc_pkg::COORD_W;
  localparam int DF = soc_pkg::DIFF_W;
  localparam int DV = soc_pkg::DIV_W;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_SQ   = 10'b0000000010,
    S_SUM  = 10'b0000000100,
    S_ROOT = 10'b0000001000,
    S_DIVS = 10'b0000010000,
    S_DIVX = 10'b0000100000,
    S_DIVY = 10'b0001000000,
    S_PNT  = 10'b0010000000,
    S_SCAN = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state;

  // Configuration registers
  logic signed [CO-1:0] min_x, max_x, min_y, max_y;
  logic [soc_pkg::FRAC_W-1:0] radius, spacing;
  logic [2*soc_pkg::FRAC_W-1:0] r2;

  // Obstacle table
  logic signed [CO-1:0] obs_x [OBSTACLE_DEPTH];
  logic signed [CO-1:0] obs_y [OBSTACLE_DEPTH];
  logic [CW-1:0] count;

  // Segment setup
  logic signed [CO-1:0] xa, ya;
  logic signed [DF-1:0] dx, dy;
  logic [CO-1:0] adx, ady;
  logic [2*CO-1:0] sqx, sqy;
  logic [SW-1:0] steps;
  logic signed [DF-1:0] dqx, dqy, qx, qy;
  logic [SW-1:0] drx, dry, rx, ry;
  logic [SW-1:0] pi;

  // Point scan
  logic signed [CO-1:0] px, py;
  logic [CW-1:0] scan_k;
  logic p1, p2, p3;
  logic signed [CO-1:0] rd_x, rd_y;
  logic [CO-1:0] aex, aey;
  logic [2*CO-1:0] sex, sey;
  logic issue, hit, scan_clear;

  // Result
  logic res_free;
  logic [1:0] res_status;
  logic res_load;

  // Shared units
  logic div_go;
  soc_pkg::div_req_t div_req;
  soc_pkg::div_rsp_t div_rsp;
  soc_pkg::sq_cell_t chain [soc_pkg::SQ_W+1];

  logic accept;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Load the result register once it is empty or being taken
  assign res_load = (state == S_DONE) && (!out_valid || !out_stall);

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      min_x   <= soc_pkg::RST_MIN;
      max_x   <= soc_pkg::RST_MAX;
      min_y   <= soc_pkg::RST_MIN;
      max_y   <= soc_pkg::RST_MAX;
      radius  <= soc_pkg::RST_RADIUS;
      spacing <= soc_pkg::RST_SPACING;
    end else if (cfg_write) begin
      unique case (cfg_index)
        soc_pkg::REG_MIN_X:   min_x   <= cfg_data;
        soc_pkg::REG_MAX_X:   max_x   <= cfg_data;
        soc_pkg::REG_MIN_Y:   min_y   <= cfg_data;
        soc_pkg::REG_MAX_Y:   max_y   <= cfg_data;
        soc_pkg::REG_RADIUS:  radius  <= cfg_data[soc_pkg::FRAC_W-1:0];
        soc_pkg::REG_SPACING: spacing <= cfg_data[soc_pkg::FRAC_W-1:0];
        default: ;
      endcase
    end
    r2 <= radius * radius;
  end

  // Absolute differences of the held segment
  always_comb begin
    adx = dx[DF-1] ? CO'(-dx) : CO'(dx);
    ady = dy[DF-1] ? CO'(-dy) : CO'(dy);
  end

  // --------------------------------------------------------------------------
  // Square root: a row of cells, one root bit each
  // --------------------------------------------------------------------------
  always_comb begin
    chain[0].valid = (state == S_SUM);
    chain[0].rem   = '0;
    chain[0].root  = '0;
    chain[0].n     = (2*soc_pkg::SQ_W)'({1'b0, sqx} + {1'b0, sqy});
  end

  for (genvar g = 0; g < soc_pkg::SQ_W; g++) begin : g_root
    soc_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_in  (chain[g]),
      .cell_out (chain[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // Shared divider
  // --------------------------------------------------------------------------
  logic [soc_pkg::FRAC_W-1:0] spacing_eff;
  assign spacing_eff = (spacing == '0) ? soc_pkg::FRAC_W'(1) : spacing;

  // Hold the root until the steps division has latched it
  logic [soc_pkg::SQ_W-1:0] root_hold;
  always_ff @(posedge clk) begin
    if (chain[soc_pkg::SQ_W].valid) begin
      root_hold <= chain[soc_pkg::SQ_W].root;
    end
  end

  always_comb begin
    div_req.start    = div_go;
    div_req.dividend = DV'(root_hold);
    div_req.divisor  = DV'(spacing_eff);
    if (state == S_DIVX) begin
      div_req.dividend = DV'(adx);
      div_req.divisor  = DV'(steps);
    end else if (state == S_DIVY) begin
      div_req.dividend = DV'(ady);
      div_req.divisor  = DV'(steps);
    end
  end

  soc_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Floor step of i*d/steps from the unsigned division of |d|
  logic signed [DF-1:0] qa_s, dq_c;
  logic [SW-1:0] ra_s, dr_c;
  logic d_neg;
  always_comb begin
    qa_s  = DF'(div_rsp.quotient);
    ra_s  = div_rsp.remainder[SW-1:0];
    d_neg = (state == S_DIVX) ? dx[DF-1] : dy[DF-1];
    dq_c  = qa_s;
    dr_c  = ra_s;
    if (d_neg) begin
      if (ra_s != '0) begin
        dq_c = ~qa_s;
        dr_c = steps - ra_s;
      end else begin
        dq_c = -qa_s;
        dr_c = '0;
      end
    end
  end

  logic [DV:0] steps_full;
  assign steps_full = {1'b0, div_rsp.quotient} + (DV+1)'(1);

  // Start the divider on the root, then on each axis once steps is known
  always_ff @(posedge clk) begin
    if (rst) begin
      div_go <= 1'b0;
    end else begin
      div_go <= ((state == S_ROOT) && chain[soc_pkg::SQ_W].valid) ||
                ((state == S_DIVS) && div_rsp.done &&
                 (steps_full <= (DV+1)'(MAX_STEPS))) ||
                ((state == S_DIVX) && div_rsp.done);
    end
  end

  // Next sample point: advance quotient and remainder by one step each
  logic [SW:0] rx_sum, ry_sum;
  logic signed [DF-1:0] px_c, py_c;
  logic out_bounds;
  always_comb begin
    rx_sum = {1'b0, rx} + {1'b0, drx};
    ry_sum = {1'b0, ry} + {1'b0, dry};
    px_c = DF'(xa) + qx;
    py_c = DF'(ya) + qy;
    out_bounds = (CO'(px_c) < min_x) || (CO'(px_c) > max_x) ||
                 (CO'(py_c) < min_y) || (CO'(py_c) > max_y);
  end

  // --------------------------------------------------------------------------
  // Obstacle scan pipeline: read, difference, square, compare
  // --------------------------------------------------------------------------
  logic signed [DF-1:0] ex, ey;
  always_comb begin
    issue = (state == S_SCAN) && !hit && (scan_k < count);
    ex = DF'(px) - DF'(rd_x);
    ey = DF'(py) - DF'(rd_y);
    hit = p3 && (({1'b0, sex} + {1'b0, sey}) < (2*CO+1)'(r2));
    scan_clear = (scan_k == count) && !p1 && !p2 && !p3;
  end

  always_ff @(posedge clk) begin
    if (accept && (mode == soc_pkg::MODE_ADD) && (count < CW'(OBSTACLE_DEPTH))) begin
      obs_x[count[AW-1:0]] <= x_a;
      obs_y[count[AW-1:0]] <= y_a;
    end
    if (issue) begin
      rd_x <= obs_x[scan_k[AW-1:0]];
      rd_y <= obs_y[scan_k[AW-1:0]];
    end
    aex <= ex[DF-1] ? CO'(-ex) : CO'(ex);
    aey <= ey[DF-1] ? CO'(-ey) : CO'(ey);
    sex <= aex * aex;
    sey <= aey * aey;
  end

  always_ff @(posedge clk) begin
    if (rst || (state != S_SCAN)) begin
      p1 <= 1'b0;
      p2 <= 1'b0;
      p3 <= 1'b0;
    end else begin
      p1 <= issue;
      p2 <= p1;
      p3 <= p2;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_free <= 1'b0;
            unique case (mode)
              soc_pkg::MODE_CLEAR: begin
                count      <= '0;
                res_status <= soc_pkg::ST_OK;
                state      <= S_DONE;
              end
              soc_pkg::MODE_ADD: begin
                state <= S_DONE;
                if (count < CW'(OBSTACLE_DEPTH)) begin
                  count      <= count + 1'b1;
                  res_status <= soc_pkg::ST_OK;
                end else begin
                  res_status <= soc_pkg::ST_FULL;
                end
              end
              soc_pkg::MODE_CHECK: begin
                res_status <= soc_pkg::ST_OK;
                xa    <= x_a;
                ya    <= y_a;
                dx    <= DF'(x_b) - DF'(x_a);
                dy    <= DF'(y_b) - DF'(y_a);
                state <= S_SQ;
              end
              default: begin
                res_status <= soc_pkg::ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_SQ: begin
          sqx   <= adx * adx;
          sqy   <= ady * ady;
          state <= S_SUM;
        end
        S_SUM: begin
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (chain[soc_pkg::SQ_W].valid) begin
            state <= S_DIVS;
          end
        end
        S_DIVS: begin
          if (div_rsp.done) begin
            if (steps_full > (DV+1)'(MAX_STEPS)) begin
              res_status <= soc_pkg::ST_LONG;
              state      <= S_DONE;
            end else begin
              steps <= steps_full[SW-1:0];
              state <= S_DIVX;
            end
          end
        end
        S_DIVX: begin
          if (div_rsp.done) begin
            dqx   <= dq_c;
            drx   <= dr_c;
            state <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_rsp.done) begin
            dqy   <= dq_c;
            dry   <= dr_c;
            qx    <= '0;
            qy    <= '0;
            rx    <= '0;
            ry    <= '0;
            pi    <= '0;
            state <= S_PNT;
          end
        end
        S_PNT: begin
          px     <= CO'(px_c);
          py     <= CO'(py_c);
          scan_k <= '0;
          state  <= out_bounds ? S_DONE : S_SCAN;
        end
        S_SCAN: begin
          if (issue) begin
            scan_k <= scan_k + 1'b1;
          end
          if (hit) begin
            state <= S_DONE;
          end else if (scan_clear) begin
            if (pi == steps) begin
              res_free <= 1'b1;
              state    <= S_DONE;
            end else begin
              // advance to the next point
              pi <= pi + 1'b1;
              if (rx_sum >= {1'b0, steps}) begin
                rx <= SW'(rx_sum - {1'b0, steps});
                qx <= qx + dqx + DF'(1);
              end else begin
                rx <= rx_sum[SW-1:0];
                qx <= qx + dqx;
              end
              if (ry_sum >= {1'b0, steps}) begin
                ry <= SW'(ry_sum - {1'b0, steps});
                qy <= qy + dqy + DF'(1);
              end else begin
                ry <= ry_sum[SW-1:0];
                qy <= qy + dqy;
              end
              state <= S_PNT;
            end
          end
        end
        S_DONE: begin
          // hold until the result register is free
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result valid: set on load, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      path_free      <= res_free;
      status         <= res_status;
      obstacle_count <= count;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(OBSTACLE_DEPTH))
    else $error("obstacle count beyond table depth");

  a_add_counts: assert property (@(posedge clk) disable iff (rst)
    (accept && (mode == soc_pkg::MODE_ADD) && (count < CW'(OBSTACLE_DEPTH)))
      |=> (count == $past(count) + 1'b1))
    else $error("accepted add did not grow the table");

  a_root_timing: assert property (@(posedge clk) disable iff (rst)
    chain[soc_pkg::SQ_W].valid |-> (state == S_ROOT))
    else $error("root left the cell row outside its wait state");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> ((state == S_DIVS) || (state == S_DIVX) || (state == S_DIVY)))
    else $error("divider finished outside a divide state");

  a_free_needs_points: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && !hit && scan_clear && (pi == steps)) |=> res_free)
    else $error("clear final point did not mark the path free");

endmodule

>>> src/soc_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soc_sqrt_cell: one digit of the integer square root
// Takes two radicand bits, settles one root bit and hands the word on.
// ----------------------------------------------------------------------------
module soc_sqrt_cell (
  input  logic              clk,
  input  logic              rst,
  input  soc_pkg::sq_cell_t cell_in,
  output soc_pkg::sq_cell_t cell_out
);

  logic [soc_pkg::SQ_REM_W+1:0] rs;
  logic [soc_pkg::SQ_REM_W+1:0] trial;
  logic [soc_pkg::SQ_REM_W+1:0] diff;
  logic                         ge;

  always_comb begin
    rs    = {cell_in.rem, cell_in.n[2*soc_pkg::SQ_W-1 -: 2]};
    trial = {2'b00, cell_in.root, 2'b01};
    diff  = rs - trial;
    ge    = (rs >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else begin
      cell_out.valid <= cell_in.valid;
    end
    cell_out.rem  <= ge ? diff[soc_pkg::SQ_REM_W-1:0] : rs[soc_pkg::SQ_REM_W-1:0];
    cell_out.root <= {cell_in.root[soc_pkg::SQ_W-2:0], ge};
    cell_out.n    <= {cell_in.n[2*soc_pkg::SQ_W-3:0], 2'b00};
  end

endmodule

>>> src/soc_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soc_divider: restoring unsigned divider
// One quotient bit per cycle; pulses done with quotient and remainder.
// ----------------------------------------------------------------------------
module soc_divider (
  input  logic              clk,
  input  logic              rst,
  input  soc_pkg::div_req_t req,
  output soc_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(soc_pkg::DIV_W + 1);

  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic [soc_pkg::DIV_W-1:0]  den;
  logic [soc_pkg::DIV_W-1:0]  r;
  logic [soc_pkg::DIV_W-1:0]  q;
  logic [soc_pkg::DIV_W:0]    t;
  logic [soc_pkg::DIV_W:0]    t_sub;
  logic                       ge;

  always_comb begin
    t     = {r, q[soc_pkg::DIV_W-1]};
    t_sub = t - {1'b0, den};
    ge    = (t >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
      cnt      <= '0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(soc_pkg::DIV_W - 1)) begin
          busy     <= 1'b0;
          rsp.done <= 1'b1;
        end
      end
    end
    if (req.start) begin
      den <= req.divisor;
      r   <= '0;
      q   <= req.dividend;
    end else if (busy) begin
      r <= ge ? t_sub[soc_pkg::DIV_W-1:0] : t[soc_pkg::DIV_W-1:0];
      q <= {q[soc_pkg::DIV_W-2:0], ge};
    end
  end

  assign rsp.quotient  = q;
  assign rsp.remainder = r;

endmodule
